FILE: src/tld_pkg.sv
// Shared widths, defaults, opcodes and controller states of the tree ancestor block.
package tld_pkg;

  // Field widths of the stream transactions.
  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 10;
  localparam int PATH_W  = 11;

  // Packed stream data widths, rounded up to whole bytes.
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 24;

  // Default sizing of the tree storage.
  localparam int NODE_COUNT_DEF  = 1024;
  localparam int LIFT_LEVELS_DEF = 10;

  // Operation carried in tuser.
  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } tld_op_e;

  // Controller states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INDEX,
    ST_ADD_RD_DEP,
    ST_ADD_WR_DEP,
    ST_ADD_RD_JMP,
    ST_ADD_WR_JMP,
    ST_Q_RD_DA,
    ST_Q_RD_DB,
    ST_Q_ORDER,
    ST_Q_LIFT,
    ST_Q_LIFT_WB,
    ST_Q_DESC_RS,
    ST_Q_DESC_RD,
    ST_Q_DESC_CMP,
    ST_Q_FIN_RD,
    ST_Q_FIN,
    ST_Q_RD_DL,
    ST_Q_OUT
  } tld_state_e;

endpackage

FILE: src/tld_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module tld_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered: data valid in the cycle after the request.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/tree_lca_distance.sv
// Top level: binary-lifting tree store with lowest common ancestor and path length queries.
//
// Input stream (s_axis): tuser carries the operation (add or query), tdata the two node
// numbers. An add attaches node_a under node_b (node_b of zero makes a root) and gives
// no result. A query returns one transaction on m_axis with the lowest common ancestor
// of node_a and node_b and the number of edges between them.
// Items are handled one at a time: the next item is taken only once the controller is
// back idle. An add of node zero does nothing. An add reads the parent depth, then writes
// the depth and one ancestor row per lifting level. A query reads both depths, lifts the
// deeper node by the set bits of the depth difference and, unless the lifted node already
// is the other node, descends the levels from the top; it ends reading the ancestor depth.
// Every lifting step is one dependent read through the single read port of the ancestor
// memory, and a descent level compares two entries.
// The result sits in an output register, so a new item is accepted while a result
// still waits; a query then waits at its end until the receiver takes the older result.
// Reset clears the controller and the output valid flag; the memories keep their
// contents, and node zero reads as its own ancestor at depth zero without being stored.
module tree_lca_distance #(
  parameter int NODE_COUNT  = tld_pkg::NODE_COUNT_DEF,
  parameter int LIFT_LEVELS = tld_pkg::LIFT_LEVELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input transaction.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata fields from bit 0: node_a [9:0], node_b [19:10], zero fill [23:20].
  input  logic [tld_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser fields from bit 0: op [0].
  input  logic                           s_axis_tuser_i,
  // Result transaction.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata fields from bit 0: ancestor [9:0], path_length [20:10], zero fill [23:21].
  output logic [tld_pkg::M_TDATA_W-1:0]  m_axis_tdata_o
);

  import tld_pkg::*;

  // Storage sizing. Node numbers never exceed the 10-bit field.
  localparam int ROWS       = (NODE_COUNT < (1 << NODE_W)) ? NODE_COUNT : (1 << NODE_W);
  localparam int IDX_W      = $clog2(ROWS);
  localparam int LA_W       = $clog2(LIFT_LEVELS);
  localparam int LC_W       = $clog2(LIFT_LEVELS + 1);
  localparam int JT_DEPTH   = ROWS * (2 ** LA_W);
  localparam int RECIP      = (1 << 20) / ROWS;
  localparam int PATH_MAX   = 2 * (NODE_COUNT - 1);
  localparam int PATH_TOP   = (PATH_MAX < (1 << PATH_W)) ? PATH_MAX : (1 << PATH_W) - 1;

  localparam logic [LC_W-1:0]    LVL_END    = LC_W'(LIFT_LEVELS);
  localparam logic [LC_W-1:0]    LVL_LAST   = LC_W'(LIFT_LEVELS - 1);
  localparam logic [DEPTH_W-1:0] DEPTH_CLMP = DEPTH_W'(NODE_COUNT - 1);
  localparam logic [PATH_W-1:0]  PATH_CLAMP = PATH_W'(PATH_TOP);

  // Controller state and datapath registers.
  tld_state_e          state_q, state_d;
  logic [LC_W-1:0]     lvl_q, lvl_d;
  logic                out_valid_q, out_valid_d;
  logic                jz_q, dz_q;

  logic                op_q, op_d;
  logic [NODE_W-1:0]   raw_a_q, raw_a_d, raw_b_q, raw_b_d;
  logic [NODE_W-1:0]   quo_a_q, quo_a_d, quo_b_q, quo_b_d;
  logic [IDX_W-1:0]    a_q, a_d, b_q, b_d;
  logic [IDX_W-1:0]    deep_q, deep_d, shal_q, shal_d, js_q, js_d, lca_q, lca_d;
  logic [DEPTH_W-1:0]  da_q, da_d, db_q, db_d, diff_q, diff_d;
  logic [NODE_W-1:0]   out_anc_q, out_anc_d;
  logic [PATH_W-1:0]   out_len_q, out_len_d;

  // Memory ports.
  logic                jt_we, jt_re;
  logic [IDX_W-1:0]    jt_wnode, jt_rnode;
  logic [LA_W-1:0]     jt_wlvl, jt_rlvl;
  logic [IDX_W-1:0]    jt_wdata, jt_rdata, jrd;
  logic                dp_we, dp_re;
  logic [IDX_W-1:0]    dp_waddr, dp_raddr;
  logic [DEPTH_W-1:0]  dp_wdata, dp_rdata, drd;

  // Helper values.
  logic [31:0]          prod_a, prod_b, qm_a, qm_b, rem_a, rem_b;
  logic [LIFT_LEVELS-1:0] lift_bits;
  logic [DEPTH_W:0]     dep_inc;
  logic signed [DEPTH_W+2:0] len_s;
  logic [31:0]          len_w;
  logic [LC_W-1:0]      lvl_prev;

  tld_ram #(
    .WIDTH (IDX_W),
    .DEPTH (JT_DEPTH)
  ) u_jump_ram (
    .clk_i   (clk_i),
    .we_i    (jt_we),
    .waddr_i ({jt_wnode, jt_wlvl}),
    .wdata_i (jt_wdata),
    .re_i    (jt_re),
    .raddr_i ({jt_rnode, jt_rlvl}),
    .rdata_o (jt_rdata)
  );

  tld_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (ROWS)
  ) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (dp_we),
    .waddr_i (dp_waddr),
    .wdata_i (dp_wdata),
    .re_i    (dp_re),
    .raddr_i (dp_raddr),
    .rdata_o (dp_rdata)
  );

  // Node zero is the sentinel: its ancestors and its depth read as zero.
  assign jrd = jz_q ? '0 : jt_rdata;
  assign drd = dz_q ? '0 : dp_rdata;

  // Node number reduction modulo the row count: reciprocal product, then one correction.
  assign prod_a = 32'(s_axis_tdata_i[NODE_W-1:0]) * 32'(RECIP);
  assign prod_b = 32'(s_axis_tdata_i[2*NODE_W-1:NODE_W]) * 32'(RECIP);
  assign qm_a   = 32'(quo_a_q) * 32'(ROWS);
  assign qm_b   = 32'(quo_b_q) * 32'(ROWS);

  always_comb begin
    rem_a = 32'(raw_a_q) - qm_a;
    if (rem_a >= 32'(ROWS)) begin
      rem_a = rem_a - 32'(ROWS);
    end
    rem_b = 32'(raw_b_q) - qm_b;
    if (rem_b >= 32'(ROWS)) begin
      rem_b = rem_b - 32'(ROWS);
    end
  end

  // Depth difference bits that the lift applies.
  assign lift_bits = LIFT_LEVELS'(diff_q);
  assign dep_inc   = {1'b0, drd} + 1'b1;
  assign lvl_prev  = lvl_q - 1'b1;

  // Path length from the three depths; ST_Q_OUT clamps it to the legal range.
  always_comb begin
    len_s = $signed({3'b000, da_q}) + $signed({3'b000, db_q})
          - $signed({2'b00, drd, 1'b0});
    len_w = 32'($unsigned(len_s));
  end

  // Next state, memory requests and datapath updates.
  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    op_d        = op_q;
    raw_a_d     = raw_a_q;
    raw_b_d     = raw_b_q;
    quo_a_d     = quo_a_q;
    quo_b_d     = quo_b_q;
    a_d         = a_q;
    b_d         = b_q;
    deep_d      = deep_q;
    shal_d      = shal_q;
    js_d        = js_q;
    lca_d       = lca_q;
    da_d        = da_q;
    db_d        = db_q;
    diff_d      = diff_q;
    out_anc_d   = out_anc_q;
    out_len_d   = out_len_q;

    jt_we    = 1'b0;
    jt_wnode = a_q;
    jt_wlvl  = lvl_q[LA_W-1:0];
    jt_wdata = jrd;
    jt_re    = 1'b0;
    jt_rnode = deep_q;
    jt_rlvl  = lvl_q[LA_W-1:0];
    dp_we    = 1'b0;
    dp_waddr = a_q;
    dp_wdata = (32'(dep_inc) > 32'(NODE_COUNT - 1)) ? DEPTH_CLMP : dep_inc[DEPTH_W-1:0];
    dp_re    = 1'b0;
    dp_raddr = a_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d    = s_axis_tuser_i;
          raw_a_d = s_axis_tdata_i[NODE_W-1:0];
          raw_b_d = s_axis_tdata_i[2*NODE_W-1:NODE_W];
          quo_a_d = prod_a[20 +: NODE_W];
          quo_b_d = prod_b[20 +: NODE_W];
          state_d = ST_INDEX;
        end
      end
      ST_INDEX: begin
        a_d = rem_a[IDX_W-1:0];
        b_d = rem_b[IDX_W-1:0];
        if (op_q == OP_QUERY) begin
          state_d = ST_Q_RD_DA;
        end else if (rem_a[IDX_W-1:0] == '0) begin
          // Adding the sentinel node changes nothing.
          state_d = ST_IDLE;
        end else begin
          state_d = ST_ADD_RD_DEP;
        end
      end

      // Add: depth of the parent, then the ancestor row by doubling.
      ST_ADD_RD_DEP: begin
        dp_re    = 1'b1;
        dp_raddr = b_q;
        state_d  = ST_ADD_WR_DEP;
      end
      ST_ADD_WR_DEP: begin
        dp_we    = 1'b1;
        jt_we    = 1'b1;
        jt_wlvl  = '0;
        jt_wdata = b_q;
        deep_d   = b_q;
        lvl_d    = LC_W'(1);
        state_d  = ST_ADD_RD_JMP;
      end
      ST_ADD_RD_JMP: begin
        jt_re   = 1'b1;
        jt_rlvl = lvl_prev[LA_W-1:0];
        state_d = ST_ADD_WR_JMP;
      end
      ST_ADD_WR_JMP: begin
        jt_we  = 1'b1;
        deep_d = jrd;
        if (lvl_q == LVL_LAST) begin
          state_d = ST_IDLE;
        end else begin
          lvl_d   = lvl_q + 1'b1;
          state_d = ST_ADD_RD_JMP;
        end
      end

      // Query: both depths, then order the nodes by depth.
      ST_Q_RD_DA: begin
        dp_re   = 1'b1;
        state_d = ST_Q_RD_DB;
      end
      ST_Q_RD_DB: begin
        dp_re    = 1'b1;
        dp_raddr = b_q;
        da_d     = drd;
        state_d  = ST_Q_ORDER;
      end
      ST_Q_ORDER: begin
        db_d = drd;
        if (drd > da_q) begin
          deep_d = b_q;
          shal_d = a_q;
          diff_d = drd - da_q;
        end else begin
          deep_d = a_q;
          shal_d = b_q;
          diff_d = da_q - drd;
        end
        lvl_d   = '0;
        state_d = ST_Q_LIFT;
      end

      // Lift the deeper node by the set bits of the depth difference.
      ST_Q_LIFT: begin
        if (lvl_q == LVL_END) begin
          if (deep_q == shal_q) begin
            lca_d   = deep_q;
            state_d = ST_Q_RD_DL;
          end else begin
            lvl_d   = LVL_LAST;
            state_d = ST_Q_DESC_RS;
          end
        end else if (lift_bits[lvl_q[LA_W-1:0]]) begin
          jt_re   = 1'b1;
          state_d = ST_Q_LIFT_WB;
        end else begin
          lvl_d = lvl_q + 1'b1;
        end
      end
      ST_Q_LIFT_WB: begin
        deep_d  = jrd;
        lvl_d   = lvl_q + 1'b1;
        state_d = ST_Q_LIFT;
      end

      // Descend from the top level to level zero, moving up both nodes where their ancestors differ.
      ST_Q_DESC_RS: begin
        jt_re    = 1'b1;
        jt_rnode = shal_q;
        state_d  = ST_Q_DESC_RD;
      end
      ST_Q_DESC_RD: begin
        js_d    = jrd;
        jt_re   = 1'b1;
        state_d = ST_Q_DESC_CMP;
      end
      ST_Q_DESC_CMP: begin
        if (js_q != jrd) begin
          shal_d = js_q;
          deep_d = jrd;
        end
        if (lvl_q == '0) begin
          state_d = ST_Q_FIN_RD;
        end else begin
          lvl_d   = lvl_prev;
          state_d = ST_Q_DESC_RS;
        end
      end
      ST_Q_FIN_RD: begin
        jt_re   = 1'b1;
        jt_rlvl = '0;
        state_d = ST_Q_FIN;
      end
      ST_Q_FIN: begin
        lca_d   = jrd;
        state_d = ST_Q_RD_DL;
      end

      // Depth of the ancestor, then the result into the output register.
      ST_Q_RD_DL: begin
        dp_re    = 1'b1;
        dp_raddr = lca_q;
        state_d  = ST_Q_OUT;
      end
      ST_Q_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_anc_d   = NODE_W'(lca_q);
          if (len_s < 0) begin
            out_len_d = '0;
          end else if (len_w > 32'(PATH_MAX)) begin
            out_len_d = PATH_CLAMP;
          end else begin
            out_len_d = len_w[PATH_W-1:0];
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
      jz_q        <= 1'b0;
      dz_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
      if (jt_re) begin
        jz_q <= (jt_rnode == '0);
      end
      if (dp_re) begin
        dz_q <= (dp_raddr == '0);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    raw_a_q   <= raw_a_d;
    raw_b_q   <= raw_b_d;
    quo_a_q   <= quo_a_d;
    quo_b_q   <= quo_b_d;
    a_q       <= a_d;
    b_q       <= b_d;
    deep_q    <= deep_d;
    shal_q    <= shal_d;
    js_q      <= js_d;
    lca_q     <= lca_d;
    da_q      <= da_d;
    db_q      <= db_d;
    diff_q    <= diff_d;
    out_anc_q <= out_anc_d;
    out_len_q <= out_len_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(M_TDATA_W - NODE_W - PATH_W)'(0), out_len_q, out_anc_q};

  // The sentinel row is never stored.
  a_no_sentinel_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jt_we |-> jt_wnode != '0)
    else $error("ancestor row of the sentinel node written");

  // A reported path length stays within the clamp.
  a_path_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> out_len_q <= PATH_CLAMP)
    else $error("path length beyond its range");

  // A new result appears only at the end of a query.
  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q) == ST_Q_OUT)
    else $error("result raised outside the query end");

  // The descent compares only existing levels.
  a_desc_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_Q_DESC_CMP |-> lvl_q < LVL_END)
    else $error("descent level out of range");

endmodule
